FILE: sv/mf3_pkg.sv
// Shared types and constants of the 3x3 median filter.
// No dependencies; compile this file first.
package mf3_pkg;

    // Line length the stores are sized for by default.
    localparam int MAX_WIDTH_DEF = 1024;

    // Smallest frame side the position logic supports.
    localparam int MIN_DIM = 3;

    // Window size and the rank of the median within it.
    localparam int WIN_SIZE    = 9;
    localparam int MEDIAN_RANK = 5;

    // Field widths.
    localparam int PIX_W    = 32;
    localparam int ROW_W    = 12;
    localparam int OUT_COL_W = 10;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 12;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

    // One incoming pixel beat.
    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             frame_start;
    } pix_beat_t;

    // One outgoing median beat.
    typedef struct packed {
        logic [PIX_W-1:0]     median_value;
        logic [ROW_W-1:0]     out_row;
        logic [OUT_COL_W-1:0] out_col;
        logic                 frame_last;
    } med_beat_t;

endpackage

FILE: sv/mf3_stream_if.sv
// Valid/ready stream channel carrying one payload struct per beat.
// The payload type is supplied by the instantiating level (see mf3_pkg).
interface mf3_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/median_filter_3x3.sv
// Streaming 3x3 median filter over 32-bit pixel words, top level.
// Depends on mf3_pkg and on the mf3_stream_if channel interface.
//
//  channel   dir  beat payload                                 carrier
//  --------  ---  ---------------------------------------------  ---------------
//  pixels    in   pixel_value[31:0], frame_start                 mf3_stream_if
//  medians   out  median_value[31:0], out_row[11:0],             mf3_stream_if
//                 out_col[9:0], frame_last
//  wr_*      in   wr_index selects image_width / image_height    plain write port
//
// One pixel beat is taken per clock unless the output stalls. A beat passes an
// accept stage (position and line store read), one compute stage (window,
// median) and then the output register.
// Reset clears the position, the configuration and all valid flags; line
// stores and window hold garbage until written and need no clearing pass.
// A stalled output register holds the compute stage, which in turn holds
// the input; with a free output one beat a cycle flows through.
module median_filter_3x3
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    mf3_stream_if.sink             pixels,
    mf3_stream_if.source           medians,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(WIN_SIZE + 1);

    // ------------------------------------------------------------------
    // Configuration registers. Out-of-range values are clamped on use.
    // ------------------------------------------------------------------
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_IMAGE_WIDTH:  width_reg  <= wr_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= wr_data[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Last column and last row of the frame after clamping.
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;

    always_comb
    begin
        if (width_reg < WIDTH_W'(MIN_DIM))
            col_last = COL_W'(MIN_DIM - 1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            col_last = COL_W'(MAX_WIDTH - 1);
        else
            col_last = COL_W'(width_reg - WIDTH_W'(1));

        // The height register cannot exceed the upper clamp, only the lower.
        if (height_reg < HEIGHT_W'(MIN_DIM))
            row_last = ROW_W'(MIN_DIM - 1);
        else
            row_last = ROW_W'(height_reg - HEIGHT_W'(1));
    end

    // ------------------------------------------------------------------
    // Handshake and stage control.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic accept;
    logic s1_adv;

    // The compute stage moves on whenever the output register is empty or
    // is being emptied in this cycle; every beat moves, with or without a
    // result, so that the stores see each pixel exactly once.
    assign s1_adv       = s1_valid_reg && (!out_valid_reg || medians.ready);
    assign pixels.ready = !s1_valid_reg || s1_adv;
    assign accept       = pixels.valid && pixels.ready;

    // ------------------------------------------------------------------
    // Accept stage: position of the incoming pixel and what it produces.
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] pos_r;
    logic [COL_W-1:0] pos_c;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_next;
    logic [COL_W-1:0] col_m1;
    logic [31:0]      col_m1_ext;
    logic             emit;
    logic             last;

    always_comb
    begin
        // A frame start moves this very pixel to the top-left corner.
        pos_r = pixels.data.frame_start ? '0 : row_reg;
        pos_c = pixels.data.frame_start ? '0 : col_reg;

        emit = (pos_r >= ROW_W'(2)) && (pos_c >= COL_W'(2));
        last = (pos_r == row_last) && (pos_c == col_last);

        col_m1     = pos_c - COL_W'(1);
        col_m1_ext = 32'(col_m1);

        // A position left beyond the frame by a register change wraps here.
        if (pos_c >= col_last)
        begin
            col_next = '0;
            row_next = (pos_r >= row_last) ? '0 : pos_r + ROW_W'(1);
        end
        else
        begin
            col_next = pos_c + COL_W'(1);
            row_next = pos_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ------------------------------------------------------------------
    // Compute stage registers.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]     s1_pix_reg;
    logic [COL_W-1:0]     s1_addr_reg;
    logic                 s1_emit_reg;
    logic                 s1_last_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic [OUT_COL_W-1:0] s1_col_reg;
    logic                 s1_fwd_reg;
    logic [PIX_W-1:0]     fwd_upper_reg;
    logic [PIX_W-1:0]     fwd_middle_reg;
    logic [PIX_W-1:0]     rd_upper_reg;
    logic [PIX_W-1:0]     rd_middle_reg;
    logic [PIX_W-1:0]     top_s1;
    logic [PIX_W-1:0]     mid_s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pixels.data.pixel_value;
            s1_addr_reg <= pos_c;
            s1_emit_reg <= emit;
            s1_last_reg <= last;
            s1_row_reg  <= pos_r - ROW_W'(1);
            s1_col_reg  <= col_m1_ext[OUT_COL_W-1:0];
            // The line store read below misses a write made at the same edge.
            // This happens only when a frame start directly follows a beat
            // that sat in column zero, and then the departing beat's write
            // data are taken directly.
            s1_fwd_reg     <= s1_adv && (s1_addr_reg == pos_c);
            fwd_upper_reg  <= mid_s1;
            fwd_middle_reg <= s1_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: row r-2 (upper) and row r-1 (middle), by column.
    // Read when a pixel is taken, written when its beat leaves compute.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            upper_mem[s1_addr_reg]  <= mid_s1;
            middle_mem[s1_addr_reg] <= s1_pix_reg;
        end
        if (accept)
        begin
            rd_upper_reg  <= upper_mem[pos_c];
            rd_middle_reg <= middle_mem[pos_c];
        end
    end

    assign top_s1 = s1_fwd_reg ? fwd_upper_reg  : rd_upper_reg;
    assign mid_s1 = s1_fwd_reg ? fwd_middle_reg : rd_middle_reg;

    // ------------------------------------------------------------------
    // Window: the two previous columns, each top, middle, bottom.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] win_reg [6];

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_s1;
            win_reg[4] <= mid_s1;
            win_reg[5] <= s1_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // Median by rank: all pairwise compares run in parallel. Ties are
    // broken by window position, which gives a strict order; the word
    // with exactly four predecessors is the fifth smallest.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] win_v [WIN_SIZE];
    logic [PIX_W-1:0] median;

    always_comb
    begin
        win_v[0] = win_reg[0];
        win_v[1] = win_reg[3];
        win_v[2] = top_s1;
        win_v[3] = win_reg[1];
        win_v[4] = win_reg[4];
        win_v[5] = mid_s1;
        win_v[6] = win_reg[2];
        win_v[7] = win_reg[5];
        win_v[8] = s1_pix_reg;
    end

    always_comb
    begin
        logic [CNT_W-1:0] rank;
        median = '0;
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            rank = '0;
            for (int j = 0; j < WIN_SIZE; j++)
            begin
                if (j != i)
                begin
                    if ((win_v[j] < win_v[i]) || ((win_v[j] == win_v[i]) && (j < i)))
                        rank = rank + CNT_W'(1);
                end
            end
            if (rank == CNT_W'(MEDIAN_RANK - 1))
                median = median | win_v[i];
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    med_beat_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= s1_emit_reg;
        else if (medians.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            out_data_reg.median_value <= median;
            out_data_reg.out_row      <= s1_row_reg;
            out_data_reg.out_col      <= s1_col_reg;
            out_data_reg.frame_last   <= s1_last_reg;
        end
    end

    assign medians.valid = out_valid_reg;
    assign medians.data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // An empty compute stage never blocks the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> pixels.ready)
        else $error("input blocked with empty compute stage");

    // The column position stays inside the line stores.
    a_col_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < 32'(MAX_WIDTH))
        else $error("column position beyond line store depth");

    // A beat held by a stalled output keeps its pixel and column.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !medians.ready) |=>
            (s1_valid_reg && $stable(s1_pix_reg) && $stable(s1_addr_reg)))
        else $error("compute stage changed while stalled");

    // Medians belong to interior rows only.
    a_interior_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.out_row != '0))
        else $error("median emitted for the top border row");

endmodule

FILE: tb/sv/mf3_median_checker.sv
// Scoreboard for the 3x3 median filter: tracks configuration writes and pixel beats,
// predicts each median beat and compares it with what leaves the block.
// Depends on mf3_pkg and the mf3_stream_if channel interface.
module mf3_median_checker
    import mf3_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    mf3_stream_if                  pixels,
    mf3_stream_if                  medians,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output int                     mismatches,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_WORDS = 6;

    logic [WIDTH_W-1:0]   width_reg;
    logic [HEIGHT_W-1:0]  height_reg;
    logic [ROW_W-1:0]     row_pos;
    logic [OUT_COL_W-1:0] col_pos;
    logic [PIX_W-1:0]     row_above2 [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]     row_above1 [MAX_WIDTH_DEF];
    // Two previous columns of the window, each kept top, middle, bottom.
    logic [PIX_W-1:0]     win_cols [WINDOW_WORDS];
    med_beat_t            expected_medians [$];

    initial mismatches = 0;

    function automatic int unsigned active_width();
        int unsigned w;
        w = width_reg;
        if (w < MIN_DIM)
        begin
            w = MIN_DIM;
        end
        if (w > MAX_WIDTH_DEF)
        begin
            w = MAX_WIDTH_DEF;
        end
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = height_reg;
        if (h < MIN_DIM)
        begin
            h = MIN_DIM;
        end
        return h;
    endfunction

    // Insertion sort of the nine words as unsigned values.
    function automatic logic [PIX_W-1:0] fifth_smallest(
        input logic [WIN_SIZE-1:0][PIX_W-1:0] words
    );
        logic [PIX_W-1:0] key;
        int               j;
        for (int i = 1; i < WIN_SIZE; i++)
        begin
            key = words[i];
            j = i - 1;
            while (j >= 0 && words[j] > key)
            begin
                words[j+1] = words[j];
                j--;
            end
            words[j+1] = key;
        end
        return words[MEDIAN_RANK-1];
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: median check error: %s", $time, what);
        mismatches++;
    endtask

    task automatic take_pixel(input pix_beat_t beat);
        int unsigned                   w;
        int unsigned                   h;
        int unsigned                   r;
        int unsigned                   c;
        logic [PIX_W-1:0]              top_word;
        logic [PIX_W-1:0]              mid_word;
        logic [WIN_SIZE-1:0][PIX_W-1:0] nine;
        med_beat_t                     want;
        w = active_width();
        h = active_height();
        if (beat.frame_start)
        begin
            row_pos = '0;
            col_pos = '0;
        end
        r = row_pos;
        c = col_pos;
        top_word = row_above2[c];
        mid_word = row_above1[c];
        row_above2[c] = mid_word;
        row_above1[c] = beat.pixel_value;
        if (r >= 2 && c >= 2)
        begin
            nine = {win_cols[0], win_cols[1], win_cols[2], win_cols[3], win_cols[4],
                    win_cols[5], top_word, mid_word, beat.pixel_value};
            want.median_value = fifth_smallest(nine);
            want.out_row      = ROW_W'(r - 1);
            want.out_col      = OUT_COL_W'(c - 1);
            want.frame_last   = (r == h - 1) && (c == w - 1);
            expected_medians.push_back(want);
        end
        win_cols[0] = win_cols[3];
        win_cols[1] = win_cols[4];
        win_cols[2] = win_cols[5];
        win_cols[3] = top_word;
        win_cols[4] = mid_word;
        win_cols[5] = beat.pixel_value;
        if (c >= w - 1)
        begin
            col_pos = '0;
            row_pos = (r >= h - 1) ? '0 : ROW_W'(r + 1);
        end
        else
        begin
            col_pos = OUT_COL_W'(c + 1);
        end
    endtask

    task automatic check_median(input med_beat_t seen);
        med_beat_t want;
        if (expected_medians.size() == 0)
        begin
            report_mismatch($sformatf("median %h at row %0d col %0d with none pending",
                                      seen.median_value, seen.out_row, seen.out_col));
            return;
        end
        want = expected_medians.pop_front();
        if (seen.median_value !== want.median_value)
        begin
            report_mismatch($sformatf("row %0d col %0d: median %h, want %h", want.out_row,
                                      want.out_col, seen.median_value, want.median_value));
        end
        if (seen.out_row !== want.out_row)
        begin
            report_mismatch($sformatf("out_row %0d, want %0d", seen.out_row, want.out_row));
        end
        if (seen.out_col !== want.out_col)
        begin
            report_mismatch($sformatf("out_col %0d, want %0d", seen.out_col, want.out_col));
        end
        if (seen.frame_last !== want.frame_last)
        begin
            report_mismatch($sformatf("row %0d col %0d: frame_last %b, want %b", want.out_row,
                                      want.out_col, seen.frame_last, want.frame_last));
        end
    endtask

    // Outputs are checked before the pixel of the same edge is taken, since a median
    // always belongs to an earlier pixel.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            row_pos    = '0;
            col_pos    = '0;
            expected_medians.delete();
        end
        else
        begin
            if (medians.valid === 1'b1 && medians.ready === 1'b1)
            begin
                check_median(medians.data);
            end
            if (wr_en)
            begin
                if (wr_index == REG_IMAGE_WIDTH)
                begin
                    width_reg = wr_data[WIDTH_W-1:0];
                end
                else if (wr_index == REG_IMAGE_HEIGHT)
                begin
                    height_reg = wr_data[HEIGHT_W-1:0];
                end
            end
            if (pixels.valid === 1'b1 && pixels.ready === 1'b1)
            begin
                take_pixel(pixels.data);
            end
        end
        outstanding <= expected_medians.size();
    end

endmodule

FILE: tb/sv/tb_median_filter_3x3.sv
// Top of the 3x3 median filter testbench: clock, reset, pixel stimulus, output stalls
// and the verdict. Depends on mf3_pkg, mf3_stream_if, the filter and mf3_median_checker.
module tb_median_filter_3x3;
    import mf3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles allowed after the last pending median before registers are rewritten,
    // so that border pixels that give no median have left the pipeline too.
    localparam int SETTLE_CYCLES    = 4;
    localparam int DRAIN_TAIL       = 8;
    localparam int LONG_HOLD_CYCLES = 48;
    // Pixels sent on the widest line; they all stay in its first row.
    localparam int WIDE_PIXELS      = 40;
    localparam int RANDOM_PIXELS    = 300;
    // The last pixels of the run go out with neither side idling.
    localparam int CALM_TAIL        = 60;
    localparam int RUN_LIMIT_NS     = 10_000_000;

    // How the words of a frame are drawn.
    typedef enum int {
        STYLE_RANDOM,
        STYLE_NARROW,
        STYLE_EXTREME,
        STYLE_TIES
    } pix_style_e;

    // Words that put every bit at both values and tell unsigned from signed order.
    localparam logic [WIN_SIZE-1:0][PIX_W-1:0] EDGE_WORDS = {
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
        32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678
    };

    // Mostly one repeated word, so the median falls among equal values.
    localparam logic [WIN_SIZE-1:0][PIX_W-1:0] TIE_WORDS = {
        32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000,
        32'h8000_0000, 32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFF
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;

    int mismatches;
    int outstanding;

    // Stimulus control shared by the sender and the receiver processes.
    bit               src_idle_on;
    bit               sink_idle_on;
    bit               src_offering;
    bit               restart_pending;
    bit               long_hold_req;
    logic [WIDTH_W-1:0] width_now;
    int               pixels_pushed;
    logic [PIX_W-1:0] tie_word;

    mf3_stream_if #(.payload_t(pix_beat_t)) pixels_ch ();
    mf3_stream_if #(.payload_t(med_beat_t)) medians_ch ();

    median_filter_3x3 u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixels   (pixels_ch),
        .medians  (medians_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    mf3_median_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixels      (pixels_ch),
        .medians     (medians_ch),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Picks one pixel word in the style of the current frame.
    function automatic logic [PIX_W-1:0] next_pixel_word(input pix_style_e style);
        case (style)
            STYLE_NARROW:
                return PIX_W'($urandom_range(0, 15));
            STYLE_EXTREME:
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            STYLE_TIES:
                return ($urandom_range(0, 2) == 0) ? $urandom() : tie_word;
            default:
                return $urandom();
        endcase
    endfunction

    // Offers one pixel beat and returns at the edge where it is taken. Valid stays
    // high for a following beat; it only drops for an idle burst or at a pause.
    // A pending restart, left by a wider image_width, rides on this beat.
    task automatic push_pixel(input logic [PIX_W-1:0] word, input logic start_flag);
        pix_beat_t beat;
        beat.pixel_value = word;
        beat.frame_start = start_flag | restart_pending;
        restart_pending = 1'b0;
        if (src_idle_on && $urandom_range(0, 9) == 0)
        begin
            if (src_offering)
            begin
                pixels_ch.valid <= 1'b0;
                src_offering = 1'b0;
            end
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        pixels_ch.valid <= 1'b1;
        pixels_ch.data  <= beat;
        src_offering = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pixels_ch.ready !== 1'b1);
    endtask

    // Stops offering, waits until every pending median has left the block, then
    // lets the pipeline empty of border pixels as well.
    task automatic settle();
        if (src_offering)
        begin
            pixels_ch.valid <= 1'b0;
            src_offering = 1'b0;
        end
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the width register and then the height register. The block has to be
    // idle. Line store entries beyond the old width may never have been written, so a
    // wider setting makes the next beat start a new frame; a narrower one does not,
    // and a position left past the new bounds then wraps.
    task automatic program_frame(input logic [CFG_DATA_W-1:0] width_raw,
                                 input logic [CFG_DATA_W-1:0] height_raw);
        if (width_raw[WIDTH_W-1:0] > width_now)
        begin
            restart_pending = 1'b1;
        end
        width_now = width_raw[WIDTH_W-1:0];
        wr_en    <= 1'b1;
        wr_index <= REG_IMAGE_WIDTH;
        wr_data  <= width_raw;
        @(posedge clk);
        wr_index <= REG_IMAGE_HEIGHT;
        wr_data  <= height_raw;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // Sends one frame in raster order, or its first stop_after pixels. About one beat
    // in a hundred restarts the frame early, which breaks the frame in the middle.
    task automatic stream_frame(input int cols, input int rows, input pix_style_e style,
                                input bit lead_start, input int stop_after);
        int total;
        total = cols * rows;
        if (stop_after > 0 && stop_after < total)
        begin
            total = stop_after;
        end
        for (int i = 0; i < total; i++)
        begin
            push_pixel(next_pixel_word(style),
                       (i == 0 && lead_start) || $urandom_range(0, 99) == 0);
            pixels_pushed++;
        end
    endtask

    // Receiver: random stall bursts while idling is on, and one long hold-off on
    // request, counted here, during which the block fills and stops taking pixels.
    initial
    begin : median_sink
        int stall_left;
        stall_left = 0;
        medians_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                stall_left = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            else if (stall_left == 0 && sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 8);
            end
            if (stall_left > 0)
            begin
                medians_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                medians_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int                    cols;
        int                    rows;
        int                    frames;
        int                    cut;
        bit                    long_hold_done;
        pix_style_e            style;
        logic [CFG_DATA_W-1:0] width_raw;
        logic [CFG_DATA_W-1:0] height_raw;

        pixels_ch.valid = 1'b0;
        pixels_ch.data  = '0;
        wr_en           = 1'b0;
        wr_index        = REG_IMAGE_WIDTH;
        wr_data         = '0;
        src_idle_on     = 1'b1;
        sink_idle_on    = 1'b1;
        src_offering    = 1'b0;
        restart_pending = 1'b0;
        long_hold_req   = 1'b0;
        long_hold_done  = 1'b0;
        width_now       = WIDTH_RESET;
        pixels_pushed   = 0;
        tie_word        = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. All-zero register words clamp to the smallest 3x3 frame,
        // which has exactly one interior pixel, so its median is also the last one.
        program_frame('0, '0);
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            push_pixel(EDGE_WORDS[i], i == 0);
        end
        // Three beats into the next frame, then a restart with mostly equal words.
        for (int i = 0; i < 3; i++)
        begin
            push_pixel($urandom(), 1'b0);
        end
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            push_pixel(TIE_WORDS[i], i == 0);
        end

        // Widest line: all-ones width clamps to the store depth, so the first
        // pixels of the frame stay in its top row and give no median.
        settle();
        program_frame('1, CFG_DATA_W'(MIN_DIM));
        stream_frame(MAX_WIDTH_DEF, MIN_DIM, STYLE_RANDOM, 1'b1, WIDE_PIXELS);

        // Tallest frame on the narrowest line, only its first rows.
        settle();
        program_frame(CFG_DATA_W'(MIN_DIM), '1);
        stream_frame(MIN_DIM, (1 << HEIGHT_W) - 1, STYLE_NARROW, 1'b0, 60);

        // Random part: small frames, mostly well formed, some cut short or restarted.
        pixels_pushed = 0;
        cols = MIN_DIM;
        rows = MIN_DIM;
        while (pixels_pushed < RANDOM_PIXELS)
        begin
            if (!long_hold_done && pixels_pushed >= RANDOM_PIXELS / 2)
            begin
                // Steady sender against a receiver that holds off for a long time.
                settle();
                program_frame(CFG_DATA_W'(5), CFG_DATA_W'(6));
                cols = 5;
                rows = 6;
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
                long_hold_req = 1'b1;
                stream_frame(cols, rows, STYLE_RANDOM, 1'b1, 0);
                stream_frame(cols, rows, STYLE_RANDOM, 1'b0, 0);
                long_hold_done = 1'b1;
            end
            else
            begin
                if (pixels_pushed >= RANDOM_PIXELS - CALM_TAIL)
                begin
                    src_idle_on  = 1'b0;
                    sink_idle_on = 1'b0;
                end
                else
                begin
                    src_idle_on  = $urandom_range(0, 3) != 0;
                    sink_idle_on = $urandom_range(0, 3) != 0;
                end
                if (pixels_pushed == 0 || $urandom_range(0, 4) != 0)
                begin
                    cols = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(MIN_DIM, 10);
                    rows = $urandom_range(MIN_DIM, 7);
                    width_raw  = CFG_DATA_W'(cols);
                    height_raw = CFG_DATA_W'(rows);
                    // Words below the smallest side clamp up to it.
                    if (cols == MIN_DIM && $urandom_range(0, 1) == 1)
                    begin
                        width_raw = CFG_DATA_W'($urandom_range(0, MIN_DIM - 1));
                    end
                    if (rows == MIN_DIM && $urandom_range(0, 1) == 1)
                    begin
                        height_raw = CFG_DATA_W'($urandom_range(0, MIN_DIM - 1));
                    end
                    settle();
                    program_frame(width_raw, height_raw);
                end
                style = pix_style_e'($urandom_range(0, 3));
                tie_word = $urandom();
                frames = $urandom_range(1, 2);
                for (int f = 0; f < frames; f++)
                begin
                    // Some frames end early, so the next setting lands mid-frame.
                    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, cols * rows - 1) : 0;
                    stream_frame(cols, rows, style, $urandom_range(0, 3) != 0, cut);
                end
            end
        end

        // Drain: nothing pending, then a few more cycles for anything unexpected.
        if (src_offering)
        begin
            pixels_ch.valid <= 1'b0;
            src_offering = 1'b0;
        end
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Hard limit well above the slowest passing run.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/mf3_pkg.sv
sv/mf3_stream_if.sv
sv/median_filter_3x3.sv
tb/sv/mf3_median_checker.sv
tb/sv/tb_median_filter_3x3.sv
